### rtl/esc_pkg.sv
// Shared types, constants and arithmetic helpers for the sensor compensation pipeline.
package esc_pkg;

  localparam int unsigned CfgWidth     = 48;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned DivBits      = 64;
  localparam int unsigned FrontStages  = 12;
  localparam int unsigned BackStages   = 5;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_TEMP    = 3'd0,
    CFG_PRESS_A = 3'd1,
    CFG_PRESS_B = 3'd2,
    CFG_PRESS_C = 3'd3,
    CFG_HUM_A   = 3'd4,
    CFG_HUM_B   = 3'd5
  } esc_cfg_e;

  localparam logic [63:0] PressOffset = 64'd128000;
  localparam logic [63:0] PressBase   = 64'd1048576;
  localparam logic [63:0] PressScale  = 64'd3125;
  localparam logic [63:0] PressOne    = 64'h0000_8000_0000_0000;
  localparam logic [31:0] HumOffset   = 32'd76800;
  localparam logic [31:0] HumMax      = 32'd419430400;
  localparam logic [31:0] HumRound    = 32'd16384;
  localparam logic [31:0] HumBias     = 32'd2097152;
  localparam logic [31:0] HumRound2   = 32'd8192;
  localparam logic [31:0] HumHalf     = 32'd32768;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } esc_in_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [31:0]        press_q24_8;
    logic [16:0]        hum_q22_10;
    logic signed [31:0] fine_temp;
  } esc_out_t;

  typedef struct packed {
    logic [31:0] temp_centi;
    logic [31:0] fine_temp;
    logic [16:0] hum;
    logic        neg;
    logic        zero;
  } esc_side_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
    logic signed [31:0] xs;
    xs = x;
    return xs >>> n;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input logic [5:0] n);
    logic signed [63:0] xs;
    xs = x;
    return xs >>> n;
  endfunction

  function automatic logic [31:0] sx16_32(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [63:0] sx16_64(input logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

endpackage

### rtl/esc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband payload.
module esc_div import esc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  input  esc_side_t   side_i,
  output logic        valid_o,
  output logic [63:0] quo_o,
  output esc_side_t   side_o
);

  logic        v_q [DivBits];
  logic [63:0] n_q [DivBits];
  logic [63:0] r_q [DivBits];
  logic [63:0] d_q [DivBits];
  esc_side_t   s_q [DivBits];

  for (genvar k = 0; k < DivBits; k++) begin : g_stage
    logic        v_in;
    logic [63:0] n_in;
    logic [63:0] r_in;
    logic [63:0] d_in;
    esc_side_t   s_in;
    logic [63:0] r_sh;
    logic [63:0] diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign n_in = num_i;
      assign r_in = '0;
      assign d_in = den_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign n_in = n_q[k-1];
      assign r_in = r_q[k-1];
      assign d_in = d_q[k-1];
      assign s_in = s_q[k-1];
    end

    assign r_sh = {r_in[62:0], n_in[63]};
    assign ge   = (r_sh >= d_in);
    assign diff = r_sh - d_in;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k] <= {n_in[62:0], ge};
        r_q[k] <= ge ? diff : r_sh;
        d_q[k] <= d_in;
        s_q[k] <= s_in;
      end
    end
  end

  assign valid_o = v_q[DivBits-1];
  assign quo_o   = n_q[DivBits-1];
  assign side_o  = s_q[DivBits-1];

endmodule

### rtl/env_sensor_compensation.sv
// Top level of the environmental sensor compensation pipeline.
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one raw sample
//   triple per word; output channel (out_valid_o/out_ready_i/out_data_o)
//   returns temperature, pressure, humidity and fine temperature per word.
//   Calibration is loaded through cfg_we_i/cfg_idx_i/cfg_data_i while idle;
//   indexes beyond the six registers are ignored.
// Pipeline: 81 register stages lie between an accepted input word and its
//   out_valid_o: 12 stages of temperature, polynomial and humidity math,
//   64 stages of the bit-per-stage pressure divider, 5 stages of pressure
//   finishing.
// Throughput: one word per cycle unless stalled; each multiplier and divider
//   stage is registered so a new sample enters every cycle without a stall.
// Stall: when the output word is not taken, the whole pipeline holds and
//   in_ready_o drops; nothing is lost or repeated.
// Reset: all valid bits clear and the calibration registers return to zero.
module env_sensor_compensation import esc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  esc_in_t                in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output esc_out_t               out_data_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i
);

  logic [47:0] cal_temp_q, cal_pa_q, cal_pb_q, cal_pc_q;
  logic [31:0] cal_ha_q, cal_hb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp_q <= '0;
      cal_pa_q   <= '0;
      cal_pb_q   <= '0;
      cal_pc_q   <= '0;
      cal_ha_q   <= '0;
      cal_hb_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TEMP:    cal_temp_q <= cfg_data_i;
        CFG_PRESS_A: cal_pa_q   <= cfg_data_i;
        CFG_PRESS_B: cal_pb_q   <= cfg_data_i;
        CFG_PRESS_C: cal_pc_q   <= cfg_data_i;
        CFG_HUM_A:   cal_ha_q   <= cfg_data_i[31:0];
        CFG_HUM_B:   cal_hb_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = {16'b0, cal_temp_q[15:0]};
  assign t2 = sx16_32(cal_temp_q[31:16]);
  assign t3 = sx16_32(cal_temp_q[47:32]);
  assign p1 = {48'b0, cal_pa_q[15:0]};
  assign p2 = sx16_64(cal_pa_q[31:16]);
  assign p3 = sx16_64(cal_pa_q[47:32]);
  assign p4 = sx16_64(cal_pb_q[15:0]);
  assign p5 = sx16_64(cal_pb_q[31:16]);
  assign p6 = sx16_64(cal_pb_q[47:32]);
  assign p7 = sx16_64(cal_pc_q[15:0]);
  assign p8 = sx16_64(cal_pc_q[31:16]);
  assign p9 = sx16_64(cal_pc_q[47:32]);
  assign h1 = {24'b0, cal_ha_q[7:0]};
  assign h2 = sx16_32(cal_ha_q[23:8]);
  assign h3 = {24'b0, cal_ha_q[31:24]};
  assign h4 = {{20{cal_hb_q[11]}}, cal_hb_q[11:0]};
  assign h5 = {{20{cal_hb_q[23]}}, cal_hb_q[23:12]};
  assign h6 = {{24{cal_hb_q[31]}}, cal_hb_q[31:24]};

  logic                   adv;
  logic [FrontStages-1:0] fv_q;
  logic [BackStages-1:0]  bv_q;
  logic                   div_valid;
  logic [63:0]            div_quo;
  esc_side_t              div_side;
  esc_side_t              side_d;

  assign adv         = !bv_q[BackStages-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = bv_q[BackStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
      bv_q <= '0;
    end else if (adv) begin
      fv_q <= {fv_q[FrontStages-2:0], in_valid_i};
      bv_q <= {bv_q[BackStages-2:0], div_valid};
    end
  end

  // front stage registers
  logic [31:0] s1_pv1_q, s1_dd_q, s2_v1_q, s2_v2m_q, s3_fine_q;
  logic [19:0] s1_ap_q, s2_ap_q, s3_ap_q, s4_ap_q, s5_ap_q, s6_ap_q;
  logic [15:0] s1_ah_q, s2_ah_q, s3_ah_q, s4_ah_q;
  logic [31:0] s4_tc_q, s4_fine_q, s4_hm5_q, s4_hm6_q, s4_hm3_q;
  logic [63:0] s4_m1_q, s4_m5_q, s4_m2_q;
  logic [31:0] s5_tc_q, s5_fine_q, s5_hx_q, s5_hya_q, s5_hyb_q;
  logic [63:0] s5_w2a_q, s5_m3_q, s5_m5_q, s5_m2_q;
  logic [31:0] s6_tc_q, s6_fine_q, s6_hx_q, s6_hyc_q;
  logic [63:0] s6_w2_q, s6_w1b_q;
  logic [31:0] s7_tc_q, s7_fine_q, s7_hx_q, s7_hyd_q;
  logic [63:0] s7_w1c_q, s7_numa_q;
  logic [31:0] s8_tc_q, s8_fine_q, s8_hx_q, s8_hye_q;
  logic [63:0] s8_num_q, s8_den_q;
  logic [31:0] s9_tc_q, s9_fine_q, s9_hp_q;
  logic [63:0] s9_un_q, s9_ud_q;
  logic        s9_neg_q, s9_zero_q;
  logic [31:0] s10_tc_q, s10_fine_q, s10_hp_q, s10_ss_q;
  logic [63:0] s10_un_q, s10_ud_q;
  logic        s10_neg_q, s10_zero_q;
  logic [31:0] s11_tc_q, s11_fine_q, s11_hp_q, s11_hq_q;
  logic [63:0] s11_un_q, s11_ud_q;
  logic        s11_neg_q, s11_zero_q;
  logic [31:0] s12_tc_q, s12_fine_q;
  logic [16:0] s12_hum_q;
  logic [63:0] s12_un_q, s12_ud_q;
  logic        s12_neg_q, s12_zero_q;

  logic [31:0] a1, dd, tx, tc, w1s, hh, hf, hy, s10_s;
  logic [63:0] w1, pr0;

  always_comb begin
    a1    = {15'b0, in_data_i.raw_temp[19:3]} - {15'b0, t1[15:0], 1'b0};
    dd    = {16'b0, in_data_i.raw_temp[19:4]} - t1;
    tx    = s3_fine_q * 32'd5 + 32'd128;
    tc    = tx[31] ? (32'd0 - ((32'd0 - tx) >> 8)) : (tx >> 8);
    w1    = {{32{s3_fine_q[31]}}, s3_fine_q} - PressOffset;
    w1s   = s3_fine_q - HumOffset;
    hh    = w1s;
    pr0   = PressBase - {44'b0, s6_ap_q};
    hy    = asr32(s8_hye_q, 5'd14);
    s10_s = asr32(s9_hp_q, 5'd15);
    hf    = s11_hp_q - asr32(s11_hq_q, 5'd4);
    if (hf[31]) begin
      hf = '0;
    end
    if (hf > HumMax) begin
      hf = HumMax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pv1_q <= a1 * t2;
      s1_dd_q  <= dd * dd;
      s1_ap_q  <= in_data_i.raw_press;
      s1_ah_q  <= in_data_i.raw_hum;

      s2_v1_q  <= asr32(s1_pv1_q, 5'd11);
      s2_v2m_q <= asr32(s1_dd_q, 5'd12) * t3;
      s2_ap_q  <= s1_ap_q;
      s2_ah_q  <= s1_ah_q;

      s3_fine_q <= s2_v1_q + asr32(s2_v2m_q, 5'd14);
      s3_ap_q   <= s2_ap_q;
      s3_ah_q   <= s2_ah_q;

      s4_tc_q   <= tc;
      s4_fine_q <= s3_fine_q;
      s4_m1_q   <= w1 * w1;
      s4_m5_q   <= w1 * p5;
      s4_m2_q   <= w1 * p2;
      s4_hm5_q  <= h5 * hh;
      s4_hm6_q  <= hh * h6;
      s4_hm3_q  <= hh * h3;
      s4_ap_q   <= s3_ap_q;
      s4_ah_q   <= s3_ah_q;

      s5_tc_q   <= s4_tc_q;
      s5_fine_q <= s4_fine_q;
      s5_w2a_q  <= s4_m1_q * p6;
      s5_m3_q   <= s4_m1_q * p3;
      s5_m5_q   <= s4_m5_q;
      s5_m2_q   <= s4_m2_q;
      s5_hx_q   <= asr32({2'b0, s4_ah_q, 14'b0} - {h4[11:0], 20'b0} - s4_hm5_q + HumRound,
                         5'd15);
      s5_hya_q  <= asr32(s4_hm6_q, 5'd10);
      s5_hyb_q  <= asr32(s4_hm3_q, 5'd11) + HumHalf;
      s5_ap_q   <= s4_ap_q;

      s6_tc_q   <= s5_tc_q;
      s6_fine_q <= s5_fine_q;
      s6_w2_q   <= s5_w2a_q + {s5_m5_q[46:0], 17'b0} + {p4[28:0], 35'b0};
      s6_w1b_q  <= asr64(s5_m3_q, 6'd8) + {s5_m2_q[51:0], 12'b0};
      s6_hx_q   <= s5_hx_q;
      s6_hyc_q  <= s5_hya_q * s5_hyb_q;
      s6_ap_q   <= s5_ap_q;

      s7_tc_q   <= s6_tc_q;
      s7_fine_q <= s6_fine_q;
      s7_w1c_q  <= (PressOne + s6_w1b_q) * p1;
      s7_numa_q <= {pr0[32:0], 31'b0} - s6_w2_q;
      s7_hx_q   <= s6_hx_q;
      s7_hyd_q  <= asr32(s6_hyc_q, 5'd10) + HumBias;

      s8_tc_q   <= s7_tc_q;
      s8_fine_q <= s7_fine_q;
      s8_num_q  <= s7_numa_q * PressScale;
      s8_den_q  <= asr64(s7_w1c_q, 6'd33);
      s8_hx_q   <= s7_hx_q;
      s8_hye_q  <= s7_hyd_q * h2 + HumRound2;

      s9_tc_q   <= s8_tc_q;
      s9_fine_q <= s8_fine_q;
      s9_hp_q   <= s8_hx_q * hy;
      s9_un_q   <= s8_num_q[63] ? (64'd0 - s8_num_q) : s8_num_q;
      s9_ud_q   <= s8_den_q[63] ? (64'd0 - s8_den_q) : s8_den_q;
      s9_neg_q  <= s8_num_q[63] ^ s8_den_q[63];
      s9_zero_q <= (s8_den_q == 64'd0);

      s10_tc_q   <= s9_tc_q;
      s10_fine_q <= s9_fine_q;
      s10_hp_q   <= s9_hp_q;
      s10_ss_q   <= s10_s * s10_s;
      s10_un_q   <= s9_un_q;
      s10_ud_q   <= s9_ud_q;
      s10_neg_q  <= s9_neg_q;
      s10_zero_q <= s9_zero_q;

      s11_tc_q   <= s10_tc_q;
      s11_fine_q <= s10_fine_q;
      s11_hp_q   <= s10_hp_q;
      s11_hq_q   <= asr32(s10_ss_q, 5'd7) * h1;
      s11_un_q   <= s10_un_q;
      s11_ud_q   <= s10_ud_q;
      s11_neg_q  <= s10_neg_q;
      s11_zero_q <= s10_zero_q;

      s12_tc_q   <= s11_tc_q;
      s12_fine_q <= s11_fine_q;
      s12_hum_q  <= hf[28:12];
      s12_un_q   <= s11_un_q;
      s12_ud_q   <= s11_ud_q;
      s12_neg_q  <= s11_neg_q;
      s12_zero_q <= s11_zero_q;
    end
  end

  always_comb begin
    side_d.temp_centi = s12_tc_q;
    side_d.fine_temp  = s12_fine_q;
    side_d.hum        = s12_hum_q;
    side_d.neg        = s12_neg_q;
    side_d.zero       = s12_zero_q;
  end

  esc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (fv_q[FrontStages-1]),
    .num_i   (s12_un_q),
    .den_i   (s12_ud_q),
    .side_i  (side_d),
    .valid_o (div_valid),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  // back stage registers
  esc_side_t   b1_side_q, b2_side_q, b3_side_q, b4_side_q;
  logic [63:0] b1_pr_q, b2_pr_q, b3_pr_q, b4_pr_q;
  logic [63:0] b2_a_q, b2_t9_q, b2_m8_q;
  logic [63:0] b3_ll_q, b3_w2p_q, b4_w1p_q, b4_w2p_q;
  logic [31:0] b3_lh_q, b3_hl_q;
  esc_out_t    out_q;
  logic [63:0] b_a, b_prod, b_sum, b_prf;

  always_comb begin
    b_a    = asr64(b1_pr_q, 6'd13);
    b_prod = b3_ll_q + {b3_lh_q + b3_hl_q, 32'b0};
    b_sum  = b4_pr_q + b4_w1p_q + b4_w2p_q;
    b_prf  = asr64(b_sum, 6'd8) + {p7[59:0], 4'b0};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_side_q <= div_side;
      b1_pr_q   <= div_side.neg ? (64'd0 - div_quo) : div_quo;

      b2_side_q <= b1_side_q;
      b2_pr_q   <= b1_pr_q;
      b2_a_q    <= b_a;
      b2_t9_q   <= p9 * b_a;
      b2_m8_q   <= p8 * b1_pr_q;

      b3_side_q <= b2_side_q;
      b3_pr_q   <= b2_pr_q;
      b3_ll_q   <= {32'b0, b2_t9_q[31:0]} * {32'b0, b2_a_q[31:0]};
      b3_lh_q   <= b2_t9_q[31:0] * b2_a_q[63:32];
      b3_hl_q   <= b2_t9_q[63:32] * b2_a_q[31:0];
      b3_w2p_q  <= asr64(b2_m8_q, 6'd19);

      b4_side_q <= b3_side_q;
      b4_pr_q   <= b3_pr_q;
      b4_w1p_q  <= asr64(b_prod, 6'd25);
      b4_w2p_q  <= b3_w2p_q;

      out_q.temp_centi  <= b4_side_q.temp_centi;
      out_q.fine_temp   <= b4_side_q.fine_temp;
      out_q.hum_q22_10  <= b4_side_q.hum;
      out_q.press_q24_8 <= b4_side_q.zero ? 32'd0 : b_prf[31:0];
    end
  end

  assign out_data_o = out_q;

endmodule

### tb/sv/esc_checker.sv
// Checker for env_sensor_compensation: tracks calibration, predicts and compares output words.
`timescale 1ns / 1ps

module esc_checker import esc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  esc_in_t                in_data_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  esc_out_t               out_data_i,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  output int                     pending_o,
  output int                     err_count_o
);

  logic [47:0] calib [6];
  esc_out_t    expected_q [$];

  function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
    logic signed [31:0] t;
    t = x;
    return t >>> n;
  endfunction

  function automatic logic [63:0] sra64(input logic [63:0] x, input int n);
    logic signed [63:0] t;
    t = x;
    return t >>> n;
  endfunction

  function automatic logic [63:0] quot64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] un, ud, q;
    un = n[63] ? -n : n;
    ud = d[63] ? -d : d;
    q  = un / ud;
    return (n[63] ^ d[63]) ? -q : q;
  endfunction

  function automatic esc_out_t compensate(input esc_in_t s);
    logic [31:0] a_t, a_h, t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [31:0] v1, v2, d, fine, x, tc, hh, hx, hy, sq;
    logic [63:0] a_p, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] f, w1, w2, pr, press;
    esc_out_t    r;
    a_t = {12'b0, s.raw_temp};
    a_p = {44'b0, s.raw_press};
    a_h = {16'b0, s.raw_hum};
    t1 = {16'b0, calib[0][15:0]};
    t2 = {{16{calib[0][31]}}, calib[0][31:16]};
    t3 = {{16{calib[0][47]}}, calib[0][47:32]};
    p1 = {48'b0, calib[1][15:0]};
    p2 = {{48{calib[1][31]}}, calib[1][31:16]};
    p3 = {{48{calib[1][47]}}, calib[1][47:32]};
    p4 = {{48{calib[2][15]}}, calib[2][15:0]};
    p5 = {{48{calib[2][31]}}, calib[2][31:16]};
    p6 = {{48{calib[2][47]}}, calib[2][47:32]};
    p7 = {{48{calib[3][15]}}, calib[3][15:0]};
    p8 = {{48{calib[3][31]}}, calib[3][31:16]};
    p9 = {{48{calib[3][47]}}, calib[3][47:32]};
    h1 = {24'b0, calib[4][7:0]};
    h2 = {{16{calib[4][23]}}, calib[4][23:8]};
    h3 = {24'b0, calib[4][31:24]};
    h4 = {{20{calib[5][11]}}, calib[5][11:0]};
    h5 = {{20{calib[5][23]}}, calib[5][23:12]};
    h6 = {{24{calib[5][31]}}, calib[5][31:24]};

    v1   = sra32(((a_t >> 3) - (t1 << 1)) * t2, 11);
    d    = (a_t >> 4) - t1;
    v2   = sra32(sra32(d * d, 12) * t3, 14);
    fine = v1 + v2;
    x    = fine * 32'd5 + 32'd128;
    tc   = x[31] ? -((-x) >> 8) : (x >> 8);

    f  = {{32{fine[31]}}, fine};
    w1 = f - 64'd128000;
    w2 = w1 * w1 * p6;
    w2 = w2 + ((w1 * p5) << 17);
    w2 = w2 + (p4 << 35);
    w1 = sra64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
    w1 = sra64(((64'd1 << 47) + w1) * p1, 33);
    if (w1 == 64'd0) begin
      press = 64'd0;
    end else begin
      pr    = 64'd1048576 - a_p;
      pr    = quot64(((pr << 31) - w2) * 64'd3125, w1);
      w1    = sra64(p9 * sra64(pr, 13) * sra64(pr, 13), 25);
      w2    = sra64(p8 * pr, 19);
      pr    = sra64(pr + w1 + w2, 8) + (p7 << 4);
      press = {32'b0, pr[31:0]};
    end

    hh = fine - 32'd76800;
    hx = sra32((a_h << 14) - (h4 << 20) - h5 * hh + 32'd16384, 15);
    hy = sra32((sra32(sra32(hh * h6, 10) * (sra32(hh * h3, 11) + 32'd32768), 10)
                + 32'd2097152) * h2 + 32'd8192, 14);
    hh = hx * hy;
    sq = sra32(hh, 15);
    hh = hh - sra32(sra32(sq * sq, 7) * h1, 4);
    if (hh[31]) hh = 32'd0;
    if (hh > 32'd419430400) hh = 32'd419430400;

    r.temp_centi  = tc;
    r.press_q24_8 = press[31:0];
    r.hum_q22_10  = hh[28:12];
    r.fine_temp   = fine;
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    esc_out_t e;
    int       errs;
    if (!rst_ni) begin
      foreach (calib[i]) calib[i] = '0;
      err_count_o <= 0;
    end else begin
      errs = 0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TEMP, CFG_PRESS_A, CFG_PRESS_B, CFG_PRESS_C: calib[cfg_idx_i] = cfg_data_i;
          CFG_HUM_A, CFG_HUM_B: calib[cfg_idx_i] = {16'b0, cfg_data_i[31:0]};
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(compensate(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("output word with nothing expected: %h", out_data_i);
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (out_data_i.temp_centi !== e.temp_centi) begin
            $error("temp_centi expected %0d got %0d", e.temp_centi, out_data_i.temp_centi);
            errs++;
          end
          if (out_data_i.press_q24_8 !== e.press_q24_8) begin
            $error("press_q24_8 expected %0d got %0d", e.press_q24_8, out_data_i.press_q24_8);
            errs++;
          end
          if (out_data_i.hum_q22_10 !== e.hum_q22_10) begin
            $error("hum_q22_10 expected %0d got %0d", e.hum_q22_10, out_data_i.hum_q22_10);
            errs++;
          end
          if (out_data_i.fine_temp !== e.fine_temp) begin
            $error("fine_temp expected %0d got %0d", e.fine_temp, out_data_i.fine_temp);
            errs++;
          end
        end
      end
      err_count_o <= err_count_o + errs;
    end
  end

endmodule

### tb/sv/tb_top.sv
// Testbench top for env_sensor_compensation: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import esc_pkg::*;

  localparam logic [CfgIdxWidth-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxWidth-1:0] CFG_SPARE_HI = 3'd7;
  localparam int Latency  = 81;
  localparam int MaxCycle = 600000;

  logic                   clk, rst_n;
  logic                   in_valid, in_ready, out_valid, out_ready;
  esc_in_t                in_data;
  esc_out_t               out_data;
  logic                   cfg_we;
  logic [CfgIdxWidth-1:0] cfg_idx;
  logic [CfgWidth-1:0]    cfg_data;
  int                     pending, err_count, cycle_cnt;
  int                     tx_idle, rx_idle;
  logic [47:0]            cal_img [6];

  env_sensor_compensation u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  esc_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .pending_o(pending), .err_count_o(err_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle);
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MaxCycle) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_word(input esc_in_t w);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_raw(input logic [19:0] t, input logic [19:0] p, input logic [15:0] h);
    esc_in_t w;
    w.raw_temp  = t;
    w.raw_press = p;
    w.raw_hum   = h;
    send_word(w);
  endtask

  task automatic send_random(input int n);
    repeat (n) begin
      if ($urandom_range(3) == 0)
        send_raw(20'($urandom), 20'($urandom), 16'($urandom));
      else
        send_raw(20'($urandom_range(560000, 440000)), 20'($urandom_range(600000, 200000)),
                 16'($urandom_range(45000, 15000)));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (Latency + 10) @(posedge clk);
  endtask

  task automatic load_cal();
    foreach (cal_img[i]) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= esc_cfg_e'(i);
      cfg_data <= (i >= 4) ? {16'($urandom), cal_img[i][31:0]} : cal_img[i];
      @(posedge clk);
    end
    cfg_we   <= 1'b1;
    cfg_idx  <= ($urandom_range(1)) ? CFG_SPARE_LO : CFG_SPARE_HI;
    cfg_data <= {16'($urandom), 32'($urandom)};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic typical_cal(input int jitter);
    cal_img[CFG_TEMP]    = {16'(-1000 + $urandom_range(2*jitter) - jitter),
                            16'(26435 + $urandom_range(2*jitter) - jitter),
                            16'(27504 + $urandom_range(2*jitter) - jitter)};
    cal_img[CFG_PRESS_A] = {16'(3024 + $urandom_range(jitter)), 16'(-10685),
                            16'(36477 + $urandom_range(2*jitter) - jitter)};
    cal_img[CFG_PRESS_B] = {16'(-7), 16'(140 + $urandom_range(jitter)),
                            16'(2855 + $urandom_range(jitter))};
    cal_img[CFG_PRESS_C] = {16'(6000), 16'(-14600), 16'(15500 + $urandom_range(jitter))};
    cal_img[CFG_HUM_A]   = {16'b0, 8'($urandom_range(jitter)), 16'(362), 8'(75)};
    cal_img[CFG_HUM_B]   = {16'b0, 8'(30), 12'(50 + $urandom_range(jitter)),
                            12'(324 + $urandom_range(jitter))};
    load_cal();
  endtask

  task automatic random_cal();
    foreach (cal_img[i]) cal_img[i] = {16'($urandom), 32'($urandom)};
    load_cal();
  endtask

  task automatic fill_cal(input logic [47:0] v);
    foreach (cal_img[i]) cal_img[i] = v;
    load_cal();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_TEMP;
    cfg_data  = '0;
    cycle_cnt = 0;
    tx_idle   = 27;
    rx_idle   = 81;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_raw(20'd519888, 20'd415148, 16'd30000);
    send_raw(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    drain();
    typical_cal(0);
    send_raw(20'd519888, 20'd415148, 16'd30000);
    send_raw(20'd0, 20'd0, 16'd0);
    send_raw(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_raw(20'd0, 20'hFFFFF, 16'hFFFF);
    send_raw(20'hFFFFF, 20'd0, 16'd0);
    send_raw(20'd440000, 20'd300000, 16'd65535);
    send_raw(20'd560000, 20'd600000, 16'd0);
    drain();
    fill_cal(48'hFFFF_FFFF_FFFF);
    send_raw(20'd0, 20'd0, 16'd0);
    send_raw(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_raw(20'd519888, 20'd415148, 16'd30000);
    drain();
    fill_cal(48'h7FFF_7FFF_7FFF);
    send_raw(20'd0, 20'd0, 16'd0);
    send_raw(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_raw(20'd519888, 20'd415148, 16'd30000);
    drain();
    fill_cal(48'h8000_8000_8000);
    send_raw(20'd0, 20'd0, 16'd0);
    send_raw(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_raw(20'd519888, 20'd415148, 16'd30000);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 27 : (ph == 1) ? 81 : 0;
      rx_idle = (ph == 0) ? 81 : (ph == 1) ? 27 : 0;
      typical_cal(40);
      send_random(250);
      drain();
      random_cal();
      send_random(100);
      drain();
      typical_cal(200);
      send_random(250);
      drain();
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
